>>> rtl/rvp_pkg.sv
// Package for the ray vertex pick block: transaction and job types, configuration
// bundle, register indexes, fixed-point widths and reset values.
// No dependencies.
package rvp_pkg;

   localparam int MAX_VERTICES_DEFAULT = 65536;
   localparam int QUEUE_DEPTH_DEFAULT  = 4;
   localparam int INDEX_W              = 16;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // fixed-point datapath widths
   localparam int V_W         = 34;   // world - origin, 20 fraction bits
   localparam int T20_W       = 36;   // projection parameter, 20 fraction bits
   localparam int DIFF_W      = 40;   // perpendicular offset, 20 fraction bits
   localparam int MUL_A_W     = 36;
   localparam int MUL_B_W     = 17;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = 54;
   localparam int XFORM_SHIFT = 12;
   localparam int PROJ_SHIFT  = 14;
   localparam int MAG_SHIFT   = 4;

   localparam logic [63:0] ROW_X_RESET     = 64'd4096;
   localparam logic [63:0] ROW_Y_RESET     = 64'd268435456;
   localparam logic [63:0] ROW_Z_RESET     = 64'd17592186044416;
   localparam logic [47:0] ORIGIN_RESET    = 48'd0;
   localparam logic [47:0] DIRECTION_RESET = 48'd211106232532992;
   localparam logic [15:0] RADIUS_RESET    = 16'd655;

   typedef enum logic [2:0] {
      REG_ROW_X     = 3'd0,
      REG_ROW_Y     = 3'd1,
      REG_ROW_Z     = 3'd2,
      REG_ORIGIN    = 3'd3,
      REG_DIRECTION = 3'd4,
      REG_RADIUS    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic               last_vertex;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] selected_index;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic               last_vertex;
      logic [INDEX_W-1:0] index;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [63:0] row_x;
      logic [63:0] row_y;
      logic [63:0] row_z;
      logic [47:0] origin;
      logic [47:0] direction;
      logic [15:0] radius;
   } cfg_type;

   function automatic logic signed [15:0] field16(input logic [63:0] word,
                                                  input logic [1:0]  k);
      field16 = word[16*k +: 16];
   endfunction

endpackage

>>> rtl/rvp_front.sv
// Front end of the ray vertex pick block: accepts vertex transactions and tags each
// with its position in the mesh before queueing it.
// Depends on rvp_pkg.
module rvp_front #(
   parameter int MAX_VERTICES = rvp_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rvp_pkg::req_type  req_data,
   input  rvp_pkg::qstat_type qstat,
   output logic              push,
   output rvp_pkg::job_type  push_data
);

   localparam int CAP   = (MAX_VERTICES - 1 > 65535) ? 65535 : MAX_VERTICES - 1;
   localparam int CNT_W = (CAP < 2) ? 1 : $clog2(CAP + 1);
   localparam logic [CNT_W-1:0] CAP_VAL = CNT_W'(CAP);

   logic [CNT_W-1:0] count_ff, count_in;

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   always_comb begin
      push_data.pos_x       = req_data.pos_x;
      push_data.pos_y       = req_data.pos_y;
      push_data.pos_z       = req_data.pos_z;
      push_data.last_vertex = req_data.last_vertex;
      push_data.index       = rvp_pkg::INDEX_W'(count_ff);
   end

   always_comb begin
      count_in = count_ff;
      if (push) begin
         if (req_data.last_vertex) begin
            count_in = '0;
         end else if (count_ff < CAP_VAL) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/rvp_queue.sv
// Short job queue between the front end and the geometry sequencer.
// Depends on rvp_pkg.
module rvp_queue #(
   parameter int DEPTH = rvp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rvp_pkg::job_type   push_data,
   input  logic               pop,
   output rvp_pkg::job_type   pop_data,
   output rvp_pkg::qstat_type qstat
);

   localparam int PTR_W = (DEPTH < 2) ? 1 : $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rvp_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign pop_data    = entry_ff[rd_ff];
   assign qstat.full  = (cnt_ff == FULL_CNT);
   assign qstat.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/rvp_back.sv
// Back end of the ray vertex pick block: multiply-accumulate sequencer for the
// transform, ray projection and distance test, first-hit tracking and result register.
// Depends on rvp_pkg.
module rvp_back (
   input  logic              clock,
   input  logic              reset,
   input  rvp_pkg::cfg_type  cfg,
   input  logic              qempty,
   output logic              pop,
   input  rvp_pkg::job_type  pop_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rvp_pkg::rsp_type  rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_XFORM  = 8'b0000_0010,
      ST_DOT    = 8'b0000_0100,
      ST_PROJ   = 8'b0000_1000,
      ST_DIFF   = 8'b0001_0000,
      ST_MAG    = 8'b0010_0000,
      ST_SQ     = 8'b0100_0000,
      ST_DECIDE = 8'b1000_0000
   } state_type;

   localparam int V_W    = rvp_pkg::V_W;
   localparam int T20_W  = rvp_pkg::T20_W;
   localparam int DIFF_W = rvp_pkg::DIFF_W;
   localparam int ACC_W  = rvp_pkg::ACC_W;
   localparam int PROD_W = rvp_pkg::PROD_W;
   localparam int PS     = rvp_pkg::PROJ_SHIFT;
   localparam int MS     = rvp_pkg::MAG_SHIFT;

   state_type                 state_ff, state_in;
   logic [1:0]                row_ff, row_in;
   logic [1:0]                step_ff, step_in;
   rvp_pkg::job_type          job_ff, job_in;
   logic signed [V_W-1:0]     v_ff [3];
   logic signed [V_W-1:0]     v_in [3];
   logic signed [T20_W-1:0]   t20_ff, t20_in;
   logic signed [DIFF_W-1:0]  q_ff [3];
   logic signed [DIFF_W-1:0]  q_in [3];
   logic [15:0]               mag_ff [3];
   logic [15:0]               mag_in [3];
   logic                      far_ff, far_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      seen_ff, seen_in;
   logic [15:0]               pos_ff, pos_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rvp_pkg::rsp_type          rsp_ff, rsp_in;

   logic [63:0]                     row_word;
   logic [15:0]                     row_pos;
   logic signed [rvp_pkg::MUL_A_W-1:0] mul_a;
   logic signed [rvp_pkg::MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]        prod;
   logic signed [ACC_W-1:0]         prod_x;
   logic signed [ACC_W-1:0]         base;
   logic signed [ACC_W-1:0]         sum;
   logic signed [ACC_W-1:0]         qt;
   logic signed [15:0]              dir_k;
   logic [DIFF_W-1:0]               absd [3];
   logic                            far_lane [3];
   logic                            hit;
   logic                            out_free;
   logic                            seen_next;
   logic [15:0]                     pos_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pop       = (state_ff == ST_IDLE) && !qempty;

   // operand selection for the shared multiplier
   always_comb begin
      case (row_ff)
         2'd0:    row_word = cfg.row_x;
         2'd1:    row_word = cfg.row_y;
         default: row_word = cfg.row_z;
      endcase
      case (step_ff)
         2'd0:    row_pos = job_ff.pos_x;
         2'd1:    row_pos = job_ff.pos_y;
         default: row_pos = job_ff.pos_z;
      endcase
      dir_k = rvp_pkg::field16({16'b0, cfg.direction}, step_ff);
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_XFORM: begin
            mul_a = rvp_pkg::MUL_A_W'(rvp_pkg::field16(row_word, step_ff));
            mul_b = rvp_pkg::MUL_B_W'($signed(row_pos));
         end
         ST_DOT: begin
            mul_a = rvp_pkg::MUL_A_W'(v_ff[step_ff]);
            mul_b = rvp_pkg::MUL_B_W'(dir_k);
         end
         ST_PROJ: begin
            mul_a = t20_ff;
            mul_b = rvp_pkg::MUL_B_W'(dir_k);
         end
         ST_MAG: begin
            mul_a = rvp_pkg::MUL_A_W'({1'b0, cfg.radius});
            mul_b = {1'b0, cfg.radius};
         end
         ST_SQ: begin
            mul_a = rvp_pkg::MUL_A_W'({1'b0, mag_ff[step_ff]});
            mul_b = {1'b0, mag_ff[step_ff]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign prod_x = ACC_W'(prod);

   always_comb begin
      base = (ACC_W'(rvp_pkg::field16(row_word, 2'd3))
              - ACC_W'(rvp_pkg::field16({16'b0, cfg.origin}, row_ff)))
             <<< rvp_pkg::XFORM_SHIFT;
      qt   = (prod_x + (prod[PROD_W-1] ? ACC_W'((1 << PS) - 1) : ACC_W'(0))) >>> PS;
      for (int k = 0; k < 3; k++) begin
         absd[k]     = q_ff[k][DIFF_W-1] ? DIFF_W'(-q_ff[k]) : DIFF_W'(q_ff[k]);
         far_lane[k] = |absd[k][DIFF_W-1:MS+16];
      end
      hit       = !far_ff && !acc_ff[ACC_W-1] && (acc_ff != '0);
      seen_next = seen_ff || hit;
      pos_next  = (hit && !seen_ff) ? job_ff.index : pos_ff;
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      step_in      = step_ff;
      job_in       = job_ff;
      v_in         = v_ff;
      t20_in       = t20_ff;
      q_in         = q_ff;
      mag_in       = mag_ff;
      far_in       = far_ff;
      acc_in       = acc_ff;
      seen_in      = seen_ff;
      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sum          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!qempty) begin
               job_in   = pop_data;
               far_in   = 1'b0;
               row_in   = 2'd0;
               step_in  = 2'd0;
               state_in = ST_XFORM;
            end
         end
         ST_XFORM: begin
            sum    = ((step_ff == 2'd0) ? base : acc_ff) + prod_x;
            acc_in = sum;
            if (step_ff == 2'd2) begin
               v_in[row_ff] = sum[V_W-1:0];
               step_in      = 2'd0;
               if (row_ff == 2'd2) begin
                  state_in = ST_DOT;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DOT: begin
            sum    = ((step_ff == 2'd0) ? ACC_W'(0) : acc_ff) + prod_x;
            acc_in = sum;
            if (step_ff == 2'd2) begin
               step_in = 2'd0;
               if (sum[ACC_W-1]) begin
                  far_in   = 1'b1;
                  state_in = ST_DECIDE;
               end else begin
                  t20_in   = sum[T20_W+PS-1:PS];
                  state_in = ST_PROJ;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_PROJ: begin
            q_in[step_ff] = qt[DIFF_W-1:0];
            if (step_ff == 2'd2) begin
               step_in  = 2'd0;
               state_in = ST_DIFF;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIFF: begin
            for (int k = 0; k < 3; k++) begin
               q_in[k] = q_ff[k] - DIFF_W'(v_ff[k]);
            end
            state_in = ST_MAG;
         end
         ST_MAG: begin
            for (int k = 0; k < 3; k++) begin
               mag_in[k] = absd[k][MS+15:MS];
            end
            far_in   = far_ff || far_lane[0] || far_lane[1] || far_lane[2];
            acc_in   = prod_x;
            step_in  = 2'd0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            acc_in = acc_ff - prod_x;
            if (step_ff == 2'd2) begin
               step_in  = 2'd0;
               state_in = ST_DECIDE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            if (!job_ff.last_vertex) begin
               seen_in  = seen_next;
               pos_in   = pos_next;
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_in.found          = seen_next;
               rsp_in.selected_index = seen_next ? pos_next : '0;
               rsp_valid_in          = 1'b1;
               seen_in               = 1'b0;
               pos_in                = '0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         step_ff      <= '0;
         seen_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         step_ff      <= step_in;
         seen_ff      <= seen_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      v_ff   <= v_in;
      t20_ff <= t20_in;
      q_ff   <= q_in;
      mag_ff <= mag_in;
      far_ff <= far_in;
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
   end

endmodule

>>> rtl/ray_vertex_pick_core.sv
// Ray vertex pick: first mesh vertex within the hit radius of a configured ray.
// Each vertex steps through the back-end states transform, dot product,
// projection, difference, magnitude, squares and decide on the single shared
// multiplier-accumulator; one behind the ray origin skips to decide after the
// dot product. A result also waits while an earlier one is held by rsp_stall.
// Reset clears all control state and the mesh state and loads the identity
// transform, zero origin, direction (0,0,-1) and radius 655; no clearing pass.
module ray_vertex_pick_core #(
   parameter int MAX_VERTICES = rvp_pkg::MAX_VERTICES_DEFAULT,
   parameter int QUEUE_DEPTH  = rvp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rvp_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rvp_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rvp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rvp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rvp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   rvp_pkg::cfg_type   cfg_ff, cfg_in;
   rvp_pkg::job_type   push_data, pop_data;
   rvp_pkg::qstat_type qstat;
   logic               push, pop;
   logic               csr_write;
   logic [2:0]         csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[5:3];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            rvp_pkg::REG_ROW_X:     cfg_in.row_x     = pwdata;
            rvp_pkg::REG_ROW_Y:     cfg_in.row_y     = pwdata;
            rvp_pkg::REG_ROW_Z:     cfg_in.row_z     = pwdata;
            rvp_pkg::REG_ORIGIN:    cfg_in.origin    = pwdata[47:0];
            rvp_pkg::REG_DIRECTION: cfg_in.direction = pwdata[47:0];
            rvp_pkg::REG_RADIUS:    cfg_in.radius    = pwdata[15:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rvp_pkg::REG_ROW_X:     prdata = cfg_ff.row_x;
         rvp_pkg::REG_ROW_Y:     prdata = cfg_ff.row_y;
         rvp_pkg::REG_ROW_Z:     prdata = cfg_ff.row_z;
         rvp_pkg::REG_ORIGIN:    prdata = {16'b0, cfg_ff.origin};
         rvp_pkg::REG_DIRECTION: prdata = {16'b0, cfg_ff.direction};
         rvp_pkg::REG_RADIUS:    prdata = {48'b0, cfg_ff.radius};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_x     <= rvp_pkg::ROW_X_RESET;
         cfg_ff.row_y     <= rvp_pkg::ROW_Y_RESET;
         cfg_ff.row_z     <= rvp_pkg::ROW_Z_RESET;
         cfg_ff.origin    <= rvp_pkg::ORIGIN_RESET;
         cfg_ff.direction <= rvp_pkg::DIRECTION_RESET;
         cfg_ff.radius    <= rvp_pkg::RADIUS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rvp_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   rvp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   rvp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .qempty    (qstat.empty),
      .pop       (pop),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("queue reports full and empty together");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.selected_index == '0))
      else $error("index set on a mesh without a hit");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("job taken from an empty queue");

   a_radius_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == rvp_pkg::REG_RADIUS) |=>
      (cfg_ff.radius == $past(pwdata[15:0])))
      else $error("radius register not updated by write");

endmodule
